// File: hdl/htd_pkg.sv
// Shared constants, types and helpers for the Huffman tree decoder.
package htd_pkg;

    localparam int MAX_NODES    = 512;
    localparam int MAX_CODE_LEN = 16;

    localparam int NODE_W      = $clog2(MAX_NODES);
    localparam int USED_W      = $clog2(MAX_NODES + 1);
    localparam int LEN_W       = $clog2(MAX_CODE_LEN + 1);
    localparam int LEN_IN_W    = 5;
    localparam int SYM_W       = 8;
    localparam int BITS_W      = 16;
    localparam int BITS_IDX_W  = $clog2(BITS_W);
    localparam int BYTE_BITS   = 8;
    localparam int BIT_IDX_W   = $clog2(BYTE_BITS);
    localparam int BIT_CNT_W   = $clog2(BYTE_BITS + 1);
    localparam int SUM_W       = ((USED_W > LEN_W) ? USED_W : LEN_W) + 1;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [SYM_W-1:0] END_MARKER  = 8'd129;
    localparam logic [SYM_W-1:0] STAR_SYMBOL = 8'd42;

    typedef logic [NODE_W-1:0] node_t;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_DECODE = 1'b1
    } op_t;

    typedef struct packed {
        op_t                  op;
        logic [SYM_W-1:0]     sym;
        logic [BITS_W-1:0]    bits;
        logic [LEN_W-1:0]     len;
        logic [BYTE_BITS-1:0] data;
    } item_t;

    typedef struct packed {
        node_t            left;
        node_t            right;
        logic [SYM_W-1:0] sym;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    localparam entry_t FRESH_ENTRY = '{left: '0, right: '0, sym: STAR_SYMBOL};

    typedef struct packed {
        logic [SYM_W-1:0] sym;
        logic             eos;
        logic             bad;
    } result_t;

    typedef struct packed {
        result_t res;
        logic    last;
    } out_t;

    typedef struct packed {
        logic stream_ended;
        logic pend_valid;
    } status_t;

    // Code bit at a position; positions past the code word read as zero.
    function automatic logic code_bit(input logic [BITS_W-1:0] bits,
                                      input logic [LEN_W-1:0] pos);
        return (32'(pos) < BITS_W) ? bits[BITS_IDX_W'(pos)] : 1'b0;
    endfunction

endpackage

// File: hdl/htd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module htd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        // hold read data while no read is issued
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: hdl/htd_front.sv
// Front end: accepts input words, classifies them and queues them for the back end.
module htd_front
    import htd_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_action,
    input  logic [SYM_W-1:0]     s_symbol,
    input  logic [BITS_W-1:0]    s_code_bits,
    input  logic [LEN_IN_W-1:0]  s_code_length,
    input  logic [BYTE_BITS-1:0] s_data_byte,
    output logic                 q_valid,
    output item_t                q_item,
    input  logic                 q_pop
);

    item_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg, count_next;
    item_t              in_item;
    logic               push, pop;

    // Saturate long codes here so the back end sees only legal lengths.
    always_comb begin
        in_item.op   = s_action ? OP_DECODE : OP_INSERT;
        in_item.sym  = s_symbol;
        in_item.bits = s_code_bits;
        in_item.len  = (32'(s_code_length) > MAX_CODE_LEN) ? LEN_W'(MAX_CODE_LEN)
                                                          : LEN_W'(s_code_length);
        in_item.data = s_data_byte;
    end

    assign s_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_item  = slot_reg[rd_ptr_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_pop && q_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                    : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                    : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

// File: hdl/htd_back.sv
// Back end: code tree store, insert walk and build, bit-serial decode walk, result output.
module htd_back
    import htd_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    q_valid,
    input  item_t   q_item,
    output logic    q_pop,
    output logic    m_valid,
    input  logic    m_ready,
    output out_t    m_out,
    output status_t status
);

    typedef enum logic [5:0] {
        S_IDLE      = 6'b000001,
        S_INS_WALK  = 6'b000010,
        S_INS_BUILD = 6'b000100,
        S_INS_FINAL = 6'b001000,
        S_DEC_STEP  = 6'b010000,
        S_DEC_FLUSH = 6'b100000
    } state_t;

    state_t                 state_reg, state_next;
    item_t                  item_reg, item_next;
    node_t                  node_reg, node_next;
    logic [LEN_W-1:0]       depth_reg, depth_next;
    entry_t                 e_reg, e_next;
    entry_t                 root_reg, root_next;
    logic [USED_W-1:0]      nodes_used_reg, nodes_used_next;
    node_t                  walk_node_reg, walk_node_next;
    logic                   stream_ended_reg, stream_ended_next;
    logic                   src_ram_reg, src_ram_next;
    logic                   arrived_reg, arrived_next;
    logic [BIT_CNT_W-1:0]   bits_left_reg, bits_left_next;
    logic                   pend_valid_reg, pend_valid_next;
    result_t                pend_reg, pend_next;
    logic                   out_valid_reg, out_valid_next;
    out_t                   out_reg, out_next;

    logic                   ram_we, ram_re;
    node_t                  ram_waddr, ram_raddr;
    entry_t                 ram_wdata, ram_rdata;

    entry_t                 cur;
    logic                   bit_val;
    node_t                  child;
    logic                   leaf;
    logic                   out_free;
    logic                   can_emit;
    logic                   emit;
    result_t                emit_res;
    logic [SUM_W-1:0]       need;
    logic [LEN_W-1:0]       pos;
    entry_t                 upd;

    htd_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_NODES)
    ) u_tree (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // The root lives in flip-flops; all other nodes are written when created.
    assign cur      = src_ram_reg ? ram_rdata : root_reg;
    assign leaf     = (cur.left == '0) || (cur.right == '0);
    assign out_free = !out_valid_reg || m_ready;
    assign can_emit = !pend_valid_reg || out_free;
    assign need     = SUM_W'(nodes_used_reg) + SUM_W'(item_reg.len - depth_reg);
    assign pos      = LEN_W'(item_reg.len - depth_reg - 1'b1);

    always_comb begin
        bit_val = 1'b0;
        if (state_reg == S_DEC_STEP) begin
            bit_val = item_reg.data[BIT_IDX_W'(bits_left_reg - 1'b1)];
        end else begin
            bit_val = code_bit(item_reg.bits, pos);
        end
    end

    assign child = bit_val ? cur.right : cur.left;

    always_comb begin
        upd = e_reg;
        if (bit_val) begin
            upd.right = nodes_used_reg[NODE_W-1:0];
        end else begin
            upd.left = nodes_used_reg[NODE_W-1:0];
        end
    end

    always_comb begin
        state_next        = state_reg;
        item_next         = item_reg;
        node_next         = node_reg;
        depth_next        = depth_reg;
        e_next            = e_reg;
        root_next         = root_reg;
        nodes_used_next   = nodes_used_reg;
        walk_node_next    = walk_node_reg;
        stream_ended_next = stream_ended_reg;
        src_ram_next      = src_ram_reg;
        arrived_next      = arrived_reg;
        bits_left_next    = bits_left_reg;
        pend_valid_next   = pend_valid_reg;
        pend_next         = pend_reg;
        out_valid_next    = out_valid_reg && !m_ready;
        out_next          = out_reg;
        q_pop             = 1'b0;
        ram_we            = 1'b0;
        ram_waddr         = node_reg;
        ram_wdata         = e_reg;
        ram_re            = 1'b0;
        ram_raddr         = child;
        emit              = 1'b0;
        emit_res          = '{sym: '0, eos: 1'b0, bad: 1'b1};

        unique case (state_reg)
            S_IDLE: begin
                q_pop = q_valid;
                if (q_valid) begin
                    item_next = q_item;
                    if (q_item.op == OP_INSERT) begin
                        node_next    = '0;
                        depth_next   = '0;
                        src_ram_next = 1'b0;
                        state_next   = S_INS_WALK;
                    end else if (!stream_ended_reg) begin
                        // reload the walk node: an insert may have changed it
                        bits_left_next = BIT_CNT_W'(BYTE_BITS);
                        arrived_next   = 1'b0;
                        src_ram_next   = (walk_node_reg != '0);
                        ram_re         = (walk_node_reg != '0);
                        ram_raddr      = walk_node_reg;
                        state_next     = S_DEC_STEP;
                    end
                end
            end

            S_INS_WALK: begin
                if ((depth_reg < item_reg.len) && (child != '0)) begin
                    node_next    = child;
                    depth_next   = depth_reg + 1'b1;
                    ram_re       = 1'b1;
                    src_ram_next = 1'b1;
                end else begin
                    e_next = cur;
                    if (need > SUM_W'(MAX_NODES)) begin
                        // no room for the new nodes: drop the whole insert
                        state_next = S_IDLE;
                    end else if (depth_reg == item_reg.len) begin
                        state_next = S_INS_FINAL;
                    end else begin
                        state_next = S_INS_BUILD;
                    end
                end
            end

            S_INS_BUILD: begin
                // link the next fresh node below the current one
                if (node_reg == '0) begin
                    root_next = upd;
                end else begin
                    ram_we    = 1'b1;
                    ram_wdata = upd;
                end
                e_next          = FRESH_ENTRY;
                node_next       = nodes_used_reg[NODE_W-1:0];
                nodes_used_next = nodes_used_reg + 1'b1;
                depth_next      = depth_reg + 1'b1;
                if (LEN_W'(depth_reg + 1'b1) == item_reg.len) begin
                    state_next = S_INS_FINAL;
                end
            end

            S_INS_FINAL: begin
                if (node_reg == '0) begin
                    root_next     = e_reg;
                    root_next.sym = item_reg.sym;
                end else begin
                    ram_we        = 1'b1;
                    ram_wdata     = e_reg;
                    ram_wdata.sym = item_reg.sym;
                end
                state_next = S_IDLE;
            end

            S_DEC_STEP: begin
                if (arrived_reg && leaf) begin
                    if (can_emit) begin
                        emit           = 1'b1;
                        emit_res.sym   = cur.sym;
                        emit_res.eos   = (cur.sym == END_MARKER);
                        emit_res.bad   = 1'b0;
                        walk_node_next = '0;
                        arrived_next   = 1'b0;
                        src_ram_next   = 1'b0;
                        if (cur.sym == END_MARKER) begin
                            stream_ended_next = 1'b1;
                            state_next        = S_DEC_FLUSH;
                        end
                    end
                end else if (bits_left_reg == '0) begin
                    state_next = S_DEC_FLUSH;
                end else if (child == '0) begin
                    if (can_emit) begin
                        emit           = 1'b1;
                        walk_node_next = '0;
                        arrived_next   = 1'b0;
                        src_ram_next   = 1'b0;
                        bits_left_next = bits_left_reg - 1'b1;
                    end
                end else begin
                    walk_node_next = child;
                    ram_re         = 1'b1;
                    src_ram_next   = 1'b1;
                    arrived_next   = 1'b1;
                    bits_left_next = bits_left_reg - 1'b1;
                end
            end

            S_DEC_FLUSH: begin
                if (!pend_valid_reg) begin
                    state_next = S_IDLE;
                end else if (out_free) begin
                    out_next.res    = pend_reg;
                    out_next.last   = 1'b1;
                    out_valid_next  = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase

        // a new result pushes the held one out; the held one is not the last
        if (emit) begin
            if (pend_valid_reg) begin
                out_next.res   = pend_reg;
                out_next.last  = 1'b0;
                out_valid_next = 1'b1;
            end
            pend_next       = emit_res;
            pend_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= S_IDLE;
            root_reg         <= FRESH_ENTRY;
            nodes_used_reg   <= USED_W'(1);
            walk_node_reg    <= '0;
            stream_ended_reg <= 1'b0;
            src_ram_reg      <= 1'b0;
            arrived_reg      <= 1'b0;
            bits_left_reg    <= '0;
            pend_valid_reg   <= 1'b0;
            out_valid_reg    <= 1'b0;
        end else begin
            state_reg        <= state_next;
            root_reg         <= root_next;
            nodes_used_reg   <= nodes_used_next;
            walk_node_reg    <= walk_node_next;
            stream_ended_reg <= stream_ended_next;
            src_ram_reg      <= src_ram_next;
            arrived_reg      <= arrived_next;
            bits_left_reg    <= bits_left_next;
            pend_valid_reg   <= pend_valid_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg  <= item_next;
        node_reg  <= node_next;
        depth_reg <= depth_next;
        e_reg     <= e_next;
        pend_reg  <= pend_next;
        out_reg   <= out_next;
    end

    assign m_valid             = out_valid_reg;
    assign m_out               = out_reg;
    assign status.stream_ended = stream_ended_reg;
    assign status.pend_valid   = pend_valid_reg;

endmodule

// File: hdl/huffman_tree_decoder.sv
// Decode byte: pop, eight bit steps with a leaf step per symbol, end check and flush.
// Insert: pop, a walk step per existing node walked, a build step per new node linked, final write.
// Words are handled one at a time by the tree engine; a two-word queue keeps s_ready up while it has room.
// Reset (aresetn low, synchronous) empties the tree to the root alone, restarts the walk
// and clears the end-of-stream state; node RAM contents need no clearing pass.
module huffman_tree_decoder
    import htd_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_action,
    input  logic [SYM_W-1:0]     s_symbol,
    input  logic [BITS_W-1:0]    s_code_bits,
    input  logic [LEN_IN_W-1:0]  s_code_length,
    input  logic [BYTE_BITS-1:0] s_data_byte,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [SYM_W-1:0]     m_decoded_symbol,
    output logic                 m_end_of_stream,
    output logic                 m_bad_code,
    output logic                 m_last
);

    logic    q_valid;
    item_t   q_item;
    logic    q_pop;
    out_t    m_out;
    status_t status;

    htd_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_action      (s_action),
        .s_symbol      (s_symbol),
        .s_code_bits   (s_code_bits),
        .s_code_length (s_code_length),
        .s_data_byte   (s_data_byte),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .q_pop         (q_pop)
    );

    htd_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_out   (m_out),
        .status  (status)
    );

    assign m_decoded_symbol = m_out.res.sym;
    assign m_end_of_stream  = m_out.res.eos;
    assign m_bad_code       = m_out.res.bad;
    assign m_last           = m_out.last;

`ifndef SYNTHESIS
    a_eos_word: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_end_of_stream |->
            m_last && !m_bad_code && (m_decoded_symbol == END_MARKER))
        else $error("end-of-stream word must be last, clean and carry the end marker");

    a_eos_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_end_of_stream |=> status.stream_ended)
        else $error("stream not marked ended after end-of-stream word");

    a_quiet_after_end: assert property (@(posedge aclk) disable iff (!aresetn)
        status.stream_ended && !status.pend_valid && !m_valid |=> !m_valid)
        else $error("result word produced after the stream ended");

    a_bad_word: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_bad_code |-> (m_decoded_symbol == '0) && !m_end_of_stream)
        else $error("bad-code word carries a symbol");
`endif

endmodule

// File: sim/htd_checker.sv
// Predicts decoded symbols from accepted words and compares them with the result channel.
module htd_checker
    import htd_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    input  logic                 s_ready,
    input  logic                 s_action,
    input  logic [SYM_W-1:0]     s_symbol,
    input  logic [BITS_W-1:0]    s_code_bits,
    input  logic [LEN_IN_W-1:0]  s_code_length,
    input  logic [BYTE_BITS-1:0] s_data_byte,
    input  logic                 m_valid,
    input  logic                 m_ready,
    input  logic [SYM_W-1:0]     m_decoded_symbol,
    input  logic                 m_end_of_stream,
    input  logic                 m_bad_code,
    input  logic                 m_last,
    output int                   fail_count,
    output int                   open_count,
    output int                   symbol_count,
    output int                   bad_count,
    output int                   eos_count
);

    node_t            left_link [MAX_NODES];
    node_t            right_link[MAX_NODES];
    logic [SYM_W-1:0] leaf_sym  [MAX_NODES];
    int               node_count;
    node_t            walk_at;
    logic             stream_done;

    out_t symbol_q[$];
    out_t want;
    int   mismatches = 0;
    int   seen_n     = 0;
    int   bad_n      = 0;
    int   eos_n      = 0;
    int   idx;

    // Walk or grow the tree along the code, most significant code bit first.
    task automatic add_code(input logic [SYM_W-1:0] sym, input logic [BITS_W-1:0] bits,
                            input logic [LEN_IN_W-1:0] len_in);
        int    len;
        int    depth;
        int    i;
        int    fresh;
        node_t at;
        node_t nxt;
        len   = (len_in > MAX_CODE_LEN) ? MAX_CODE_LEN : int'(len_in);
        at    = '0;
        depth = 0;
        while (depth < len) begin
            nxt = bits[len - 1 - depth] ? right_link[at] : left_link[at];
            if (nxt == '0)
                break;
            at = nxt;
            depth++;
        end
        // Drop the whole code if the new nodes do not fit.
        if (node_count + (len - depth) > MAX_NODES)
            return;
        for (i = depth; i < len; i++) begin
            fresh = node_count;
            node_count++;
            left_link[fresh]  = '0;
            right_link[fresh] = '0;
            leaf_sym[fresh]   = STAR_SYMBOL;
            if (bits[len - 1 - i])
                right_link[at] = node_t'(fresh);
            else
                left_link[at] = node_t'(fresh);
            at = node_t'(fresh);
        end
        leaf_sym[at] = sym;
    endtask

    // Feed one byte into the persistent walk and queue the symbols it completes.
    task automatic walk_byte(input logic [BYTE_BITS-1:0] data);
        node_t nxt;
        out_t  held;
        out_t  got;
        logic  have;
        logic  found;
        int    k;
        have = 1'b0;
        held = '0;
        for (k = BYTE_BITS - 1; k >= 0 && !stream_done; k--) begin
            got   = '0;
            found = 1'b0;
            nxt   = data[k] ? right_link[walk_at] : left_link[walk_at];
            if (nxt == '0) begin
                got.res.bad = 1'b1;
                found       = 1'b1;
            end else begin
                walk_at = nxt;
                if (left_link[nxt] == '0 || right_link[nxt] == '0) begin
                    got.res.sym = leaf_sym[nxt];
                    got.res.eos = (leaf_sym[nxt] == END_MARKER);
                    found       = 1'b1;
                end
            end
            if (found) begin
                if (have)
                    symbol_q.push_back(held);
                held    = got;
                have    = 1'b1;
                walk_at = '0;
                if (got.res.eos)
                    stream_done = 1'b1;
            end
        end
        if (have) begin
            held.last = 1'b1;
            symbol_q.push_back(held);
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            for (idx = 0; idx < MAX_NODES; idx++) begin
                left_link[idx]  = '0;
                right_link[idx] = '0;
                leaf_sym[idx]   = STAR_SYMBOL;
            end
            node_count  = 1;
            walk_at     = '0;
            stream_done = 1'b0;
            symbol_q.delete();
        end else begin
            if (s_valid && s_ready) begin
                if (op_t'(s_action) == OP_INSERT)
                    add_code(s_symbol, s_code_bits, s_code_length);
                else
                    walk_byte(s_data_byte);
            end
            if (m_valid && m_ready) begin
                seen_n++;
                if (m_bad_code)
                    bad_n++;
                if (m_end_of_stream)
                    eos_n++;
                if (symbol_q.size() == 0) begin
                    $display("%0t: unexpected word sym %0d eos %b bad %b last %b", $time,
                             m_decoded_symbol, m_end_of_stream, m_bad_code, m_last);
                    mismatches++;
                end else begin
                    want = symbol_q.pop_front();
                    if (m_decoded_symbol !== want.res.sym) begin
                        $display("%0t: decoded_symbol expected %0d got %0d", $time,
                                 want.res.sym, m_decoded_symbol);
                        mismatches++;
                    end
                    if (m_end_of_stream !== want.res.eos) begin
                        $display("%0t: end_of_stream expected %b got %b", $time,
                                 want.res.eos, m_end_of_stream);
                        mismatches++;
                    end
                    if (m_bad_code !== want.res.bad) begin
                        $display("%0t: bad_code expected %b got %b", $time,
                                 want.res.bad, m_bad_code);
                        mismatches++;
                    end
                    if (m_last !== want.last) begin
                        $display("%0t: last expected %b got %b", $time, want.last, m_last);
                        mismatches++;
                    end
                end
            end
        end
        fail_count   <= mismatches;
        open_count   <= symbol_q.size();
        symbol_count <= seen_n;
        bad_count    <= bad_n;
        eos_count    <= eos_n;
    end

endmodule

// File: sim/tb_top.sv
// Top of the Huffman tree decoder testbench: clock, reset, word stimulus and verdict.
module tb_top;
    import htd_pkg::*;

    localparam int STALL_LIMIT = 3000;
    localparam int DRAIN_CYCLES = 64;

    logic                 aclk;
    logic                 aresetn       = 1'b0;
    logic                 s_valid       = 1'b0;
    logic                 s_ready;
    logic                 s_action      = OP_INSERT;
    logic [SYM_W-1:0]     s_symbol      = '0;
    logic [BITS_W-1:0]    s_code_bits   = '0;
    logic [LEN_IN_W-1:0]  s_code_length = '0;
    logic [BYTE_BITS-1:0] s_data_byte   = '0;
    logic                 m_valid;
    logic                 m_ready       = 1'b0;
    logic [SYM_W-1:0]     m_decoded_symbol;
    logic                 m_end_of_stream;
    logic                 m_bad_code;
    logic                 m_last;

    int fail_n;
    int open_n;
    int sym_n;
    int bad_n;
    int eos_n;
    int send_idle  = 0;
    int recv_stall = 0;
    int n_codes    = 0;
    int n_bytes    = 0;
    int quiet      = 0;
    int k;

    huffman_tree_decoder DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_action        (s_action),
        .s_symbol        (s_symbol),
        .s_code_bits     (s_code_bits),
        .s_code_length   (s_code_length),
        .s_data_byte     (s_data_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_decoded_symbol(m_decoded_symbol),
        .m_end_of_stream (m_end_of_stream),
        .m_bad_code      (m_bad_code),
        .m_last          (m_last)
    );

    htd_checker chk (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_action        (s_action),
        .s_symbol        (s_symbol),
        .s_code_bits     (s_code_bits),
        .s_code_length   (s_code_length),
        .s_data_byte     (s_data_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_decoded_symbol(m_decoded_symbol),
        .m_end_of_stream (m_end_of_stream),
        .m_bad_code      (m_bad_code),
        .m_last          (m_last),
        .fail_count      (fail_n),
        .open_count      (open_n),
        .symbol_count    (sym_n),
        .bad_count       (bad_n),
        .eos_count       (eos_n)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_stall);
    end

    // End the run if no word moves on either channel for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic logic [SYM_W-1:0] pick_symbol();
        logic [SYM_W-1:0] sym;
        do
            sym = SYM_W'($urandom_range(0, 255));
        while (sym == END_MARKER);
        return sym;
    endfunction

    task automatic send_word(input op_t act, input logic [SYM_W-1:0] sym,
                             input logic [BITS_W-1:0] bits, input logic [LEN_IN_W-1:0] len,
                             input logic [BYTE_BITS-1:0] data);
        if ($urandom_range(0, 99) < send_idle) begin
            s_valid <= 1'b0;
            do
                @(posedge aclk);
            while ($urandom_range(0, 99) < send_idle);
        end
        s_valid       <= 1'b1;
        s_action      <= act;
        s_symbol      <= sym;
        s_code_bits   <= bits;
        s_code_length <= len;
        s_data_byte   <= data;
        do
            @(posedge aclk);
        while (!s_ready);
    endtask

    task automatic send_code(input logic [SYM_W-1:0] sym, input logic [BITS_W-1:0] bits,
                             input logic [LEN_IN_W-1:0] len);
        send_word(OP_INSERT, sym, bits, len, BYTE_BITS'($urandom));
        n_codes++;
    endtask

    task automatic send_byte(input logic [BYTE_BITS-1:0] data);
        send_word(OP_DECODE, SYM_W'($urandom), BITS_W'($urandom), LEN_IN_W'($urandom), data);
        n_bytes++;
    endtask

    // Keep random codes under the left root branch so the right branch stays two leaves.
    task automatic random_code(input logic deep);
        logic [LEN_IN_W-1:0] len;
        logic [BITS_W-1:0]   bits;
        int                  roll;
        int                  eff;
        roll = $urandom_range(0, 99);
        if (deep)
            len = LEN_IN_W'($urandom_range(16, 31));
        else if (roll < 5)
            len = '0;
        else if (roll < 12)
            len = LEN_IN_W'($urandom_range(17, 31));
        else
            len = LEN_IN_W'($urandom_range(1, 16));
        bits = BITS_W'($urandom);
        eff  = (len > MAX_CODE_LEN) ? MAX_CODE_LEN : int'(len);
        if (eff > 0)
            bits[eff - 1] = 1'b0;
        send_code(pick_symbol(), bits, len);
    endtask

    task automatic run_mix(input int count);
        int i;
        for (i = 0; i < count; i++) begin
            if ($urandom_range(0, 99) < 35)
                random_code(1'b0);
            else
                send_byte(BYTE_BITS'($urandom));
        end
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Empty tree: every bit misses at the root.
        send_byte(8'hA5);
        // Zero chain of depth ten, then a lone left child acts as a star leaf.
        send_code(8'h00, 16'hFC00, 5'd10);
        send_byte(8'h80);
        // Give the zero-chain nodes at depth two to ten a right sibling leaf; the root's right child gets two leaves.
        for (k = 1; k <= 9; k++)
            send_code(SYM_W'(37 * k), 16'(16'hFFFF << (k + 1)) | 16'h0001, LEN_IN_W'(k + 1));
        send_code(8'hFF, 16'h0002, 5'd2);
        send_code(8'h55, 16'h0003, 5'd2);
        // First zero byte completes nothing.
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_code(8'h7E, 16'hFFFF, 5'd0);
        send_code(pick_symbol(), 16'h7FFF, 5'd31);
        send_code(pick_symbol(), 16'h0F0F, 5'd17);
        send_code(8'hAA, 16'hFFFF, 5'd2);
        send_byte(8'h5A);
        send_byte(8'hC3);
        send_byte(8'h81);

        run_mix(7);
        send_idle = 73;
        run_mix(7);
        send_idle  = 0;
        recv_stall = 73;
        run_mix(7);
        send_idle  = 36;
        recv_stall = 36;
        run_mix(7);

        // Long codes until the node store runs out and inserts get dropped.
        for (k = 0; k < 44; k++)
            random_code(1'b1);
        for (k = 0; k < 6; k++)
            send_byte(BYTE_BITS'($urandom));

        // Put the end marker on an existing leaf, then reach it.
        send_code(END_MARKER, 16'h0003, 5'd2);
        send_byte(8'hFF);
        send_byte(8'hFF);
        for (k = 0; k < 3; k++)
            send_byte(BYTE_BITS'($urandom));
        random_code(1'b0);
        random_code(1'b0);
        s_valid <= 1'b0;

        do
            @(posedge aclk);
        while (open_n != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Loaded %0d codes and fed %0d compressed bytes over four flow-control phases.",
                 n_codes, n_bytes);
        $display("Checked %0d symbols: %0d bad-code, %0d end-of-stream.", sym_n, bad_n, eos_n);
        if (fail_n == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// File: filelist.f
hdl/htd_pkg.sv
hdl/htd_ram.sv
hdl/htd_front.sv
hdl/htd_back.sv
hdl/huffman_tree_decoder.sv
sim/htd_checker.sv
sim/tb_top.sv
